FILE: rtl/assert_macros.svh
// Assertion shorthands shared by the ring reader RTL.
// All of them sample on clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define CRCR_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante in this cycle implies cons in the same cycle
`define CRCR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in this cycle implies the sequence cons starting next cycle
`define CRCR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crcr_pkg.sv
package crcr_pkg;

    localparam int CAPACITY = 4096;                // power of two: slot is total[ADDR_W-1:0]
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int MAX_READ = 64;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 32;

    localparam logic [1:0] CMD_CAPTURE = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic clamp;    // fit cursor into window
        logic count;    // compute beat count
        logic fetch;    // read store at cursor
        logic load;     // load output register
    } crcr_ctl_t;

    typedef struct packed {
        logic out_free;     // output register empty or draining
        logic final_beat;   // beat being loaded ends the read
    } crcr_stat_t;

endpackage

FILE: rtl/capture_ring_cursor_reader_unit.sv
// Capture window over a byte stream with a cursor-based reader.
// Input channel (in_valid/in_ready) carries cmd plus its operands:
//   capture: data_byte is written at total mod 4096, total advances.
//   restart: the 32-bit total is cleared; stored bytes are kept.
//   read:    read_cursor is fitted into [total-4096, total] (overflow set
//            if it was older), then up to min(max_len, 64) beats follow.
// Output channel (out_valid/out_ready) gives one beat per byte, each with
// next_cursor and last; an empty read gives a single beat with byte_valid 0.
// Capture and restart sustain one beat per cycle while no read is in progress.
// A read holds the input channel through the cursor clamp and count
// states, then a store read and output load per result while the output
// register is free; the first result is loaded after clamp, count, fetch.
// The read loop stops in its load step while out_ready is low and the
// output register holds an untaken beat. After the final beat is loaded
// the input channel opens again even if that beat is still waiting to be taken.
// Reset clears the total and the output valid; the byte store is not
// cleared and must be written before it is read.
module capture_ring_cursor_reader_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [7:0]                  data_byte,
    input  logic [crcr_pkg::POS_W-1:0]  read_cursor,
    input  logic [crcr_pkg::LEN_W-1:0]  max_len,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic                        overflow,
    output logic [crcr_pkg::POS_W-1:0]  next_cursor,
    output logic                        last
);
    import crcr_pkg::*;

    crcr_ctl_t  ctl;
    crcr_stat_t stat;

    crcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    crcr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .read_cursor (read_cursor),
        .max_len     (max_len),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .overflow    (overflow),
        .next_cursor (next_cursor),
        .last        (last)
    );

endmodule

FILE: rtl/crcr_ctrl.sv
`include "assert_macros.svh"

module crcr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  crcr_pkg::crcr_stat_t  stat,
    output crcr_pkg::crcr_ctl_t   ctl
);
    import crcr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLAMP = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       read_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        ctl.accept = in_valid && in_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept && (cmd == CMD_READ))
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                ctl.clamp  = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                ctl.count  = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait here while the previous beat is still stalled
                if (stat.out_free)
                begin
                    ctl.load   = 1'b1;
                    state_next = stat.final_beat ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign read_go = ctl.accept && (cmd == CMD_READ);

    `CRCR_ASSERT_NXT(a_read_to_clamp, read_go, state_reg == S_CLAMP, "read skipped clamp")
    `CRCR_ASSERT_NXT(a_clamp_to_count, state_reg == S_CLAMP, state_reg == S_COUNT, "no count")
    `CRCR_ASSERT_NXT(a_count_to_fetch, state_reg == S_COUNT, state_reg == S_FETCH, "no fetch")

endmodule

FILE: rtl/crcr_dpath.sv
`include "assert_macros.svh"

module crcr_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crcr_pkg::crcr_ctl_t         ctl,
    output crcr_pkg::crcr_stat_t        stat,
    input  logic [1:0]                  cmd,
    input  logic [7:0]                  data_byte,
    input  logic [crcr_pkg::POS_W-1:0]  read_cursor,
    input  logic [crcr_pkg::LEN_W-1:0]  max_len,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic                        overflow,
    output logic [crcr_pkg::POS_W-1:0]  next_cursor,
    output logic                        last
);
    import crcr_pkg::*;

    localparam logic [POS_W-1:0] CAP_POS  = POS_W'(CAPACITY);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_READ);

    logic [7:0]       store_mem [CAPACITY];
    logic [7:0]       rd_data_reg;

    logic [POS_W-1:0] total_reg;
    logic [POS_W-1:0] total_next;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [POS_W-1:0] cur_reg;
    logic [LEN_W-1:0] len_reg;
    logic             ovf_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             overflow_reg;
    logic [POS_W-1:0] next_cursor_reg;
    logic             last_reg;

    logic [POS_W-1:0] oldest;
    logic             stale;
    logic [POS_W-1:0] clamped;
    logic [POS_W-1:0] avail;
    logic [LEN_W-1:0] lim;
    logic             cnt_zero;
    logic             do_capture;
    logic             do_restart;
    logic             do_read;
    logic             empty_beat;

    assign do_capture = ctl.accept && (cmd == CMD_CAPTURE);
    assign do_restart = ctl.accept && (cmd == CMD_RESTART);
    assign do_read    = ctl.accept && (cmd == CMD_READ);

    // window is [oldest, total]
    assign oldest  = (total_reg > CAP_POS) ? (total_reg - CAP_POS) : '0;
    assign stale   = (cur_reg < oldest);
    assign clamped = stale ? oldest : ((cur_reg > total_reg) ? total_reg : cur_reg);

    assign avail    = total_reg - cur_reg;
    assign lim      = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
    assign cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        total_next = total_reg;
        if (do_capture)
        begin
            total_next = total_reg + POS_W'(1);
        end
        else if (do_restart)
        begin
            total_next = '0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.count)
        begin
            cnt_next = (avail > POS_W'(lim)) ? lim : avail[LEN_W-1:0];
        end
        else if (ctl.load && !cnt_zero)
        begin
            cnt_next = cnt_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_capture)
        begin
            store_mem[total_reg[ADDR_W-1:0]] <= data_byte;
        end
        if (ctl.fetch)
        begin
            rd_data_reg <= store_mem[cur_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            cur_reg <= read_cursor;
            len_reg <= max_len;
            ovf_reg <= 1'b0;
        end
        else if (ctl.clamp)
        begin
            cur_reg <= clamped;
            ovf_reg <= stale;
        end
        else if (ctl.load && !cnt_zero)
        begin
            cur_reg <= cur_reg + POS_W'(1);
        end

        if (ctl.load)
        begin
            out_byte_reg    <= cnt_zero ? 8'd0 : rd_data_reg;
            byte_valid_reg  <= !cnt_zero;
            overflow_reg    <= ovf_reg;
            next_cursor_reg <= cnt_zero ? cur_reg : (cur_reg + POS_W'(1));
            last_reg        <= (cnt_reg < LEN_W'(2));
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.final_beat = (cnt_reg < LEN_W'(2));

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign overflow    = overflow_reg;
    assign next_cursor = next_cursor_reg;
    assign last        = last_reg;

    assign empty_beat = out_valid_reg && !byte_valid_reg;

    `CRCR_ASSERT(a_cnt_bound, cnt_reg <= MAX_LEN, "beat count above read limit")
    `CRCR_ASSERT_IMP(a_fetch_in_window, ctl.fetch, avail >= POS_W'(cnt_reg), "fetch past total")
    `CRCR_ASSERT_IMP(a_empty_is_last, empty_beat, last_reg, "empty beat not last")

endmodule
